/* rtl/jcl_pkg.sv */
package jcl_pkg;

  // stick event codes
  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_PRESS = 3'd1,
    EV_UP    = 3'd2,
    EV_DOWN  = 3'd3,
    EV_RIGHT = 3'd4,
    EV_LEFT  = 3'd5
  } ev_t;

  // lock modes
  typedef enum logic [1:0] {
    MODE_INIT     = 2'd0,
    MODE_LOCKED   = 2'd1,
    MODE_UNLOCKED = 2'd2,
    MODE_CHANGE   = 2'd3
  } mode_t;

  // motor pulse codes
  typedef enum logic [1:0] {
    MOTOR_NONE  = 2'd0,
    MOTOR_OPEN  = 2'd1,
    MOTOR_CLOSE = 2'd2
  } motor_t;

  // led pulse codes
  typedef enum logic [1:0] {
    LED_NONE    = 2'd0,
    LED_ALL_ON  = 2'd1,
    LED_WRONG   = 2'd2,
    LED_DEFAULT = 2'd3
  } led_t;

  localparam int SAMPLE_W    = 10;
  localparam int THRESH_W    = 9;
  localparam logic [SAMPLE_W-1:0] REST_TOP = 10'd1000;
  localparam logic [THRESH_W-1:0] THRESH_RESET = 9'd200;

  // transfer from the classifier into the event queue
  typedef struct packed {
    logic valid;
    ev_t  ev;
  } push_t;

  // factory code, repeated every four symbols
  function automatic ev_t default_symbol(input int k);
    ev_t s;
    case (k % 4)
      0:       s = EV_UP;
      1:       s = EV_UP;
      2:       s = EV_LEFT;
      default: s = EV_RIGHT;
    endcase
    return s;
  endfunction

endpackage

/* rtl/joystick_combination_lock_unit.sv */
// Joystick combination lock.
// Input channel (in_valid / in_stall): one joystick sample pair plus the
// active-low button per transfer. Output channel (out_valid / out_stall):
// one result per input transfer, in order: mode, stick event, motor and led
// pulses, entered count and compare flags.
// cfg_wr_en / cfg_wr_data write the deflection threshold; write it only
// while no transfer is in flight.
// A result passes from the classifier into a two-entry event queue, then
// through the lock sequencer into the result register.
// Throughput: one item per cycle sustained while out_stall is low.
// When the receiver stalls, the result register holds and the queue fills;
// in_stall rises once both queue entries are taken.
// Reset: mode init, no cached direction, count zero, stored code restored
// to the factory pattern, threshold 200, both channels empty.
module joystick_combination_lock_unit #(
  parameter int CODE_LENGTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [jcl_pkg::THRESH_W-1:0] cfg_wr_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [jcl_pkg::SAMPLE_W-1:0] x_sample,
  input  logic [jcl_pkg::SAMPLE_W-1:0] y_sample,
  input  logic                         button_n,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   lock_mode,
  output logic [2:0]                   stick_event,
  output logic [1:0]                   motor_command,
  output logic [1:0]                   led_command,
  output logic [1:0]                   entered_count,
  output logic                         code_checked,
  output logic                         code_matched
);

  jcl_pkg::push_t push;
  jcl_pkg::ev_t   head;
  logic           queue_full;
  logic           queue_not_empty;
  logic           ev_pop;

  // classifier
  jcl_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .x_sample    (x_sample),
    .y_sample    (y_sample),
    .button_n    (button_n),
    .queue_full  (queue_full),
    .in_stall    (in_stall),
    .push        (push)
  );

  // event queue
  jcl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (ev_pop),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .head      (head)
  );

  // lock sequencer
  jcl_back #(
    .CODE_LENGTH (CODE_LENGTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .ev_valid      (queue_not_empty),
    .ev_in         (head),
    .ev_pop        (ev_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .lock_mode     (lock_mode),
    .stick_event   (stick_event),
    .motor_command (motor_command),
    .led_command   (led_command),
    .entered_count (entered_count),
    .code_checked  (code_checked),
    .code_matched  (code_matched)
  );

endmodule

/* rtl/jcl_front.sv */
module jcl_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [jcl_pkg::THRESH_W-1:0]   cfg_wr_data,
  input  logic                           in_valid,
  input  logic [jcl_pkg::SAMPLE_W-1:0]   x_sample,
  input  logic [jcl_pkg::SAMPLE_W-1:0]   y_sample,
  input  logic                           button_n,
  input  logic                           queue_full,
  output logic                           in_stall,
  output jcl_pkg::push_t                 push
);

  logic [jcl_pkg::THRESH_W-1:0] stick_threshold;
  logic [jcl_pkg::SAMPLE_W-1:0] hi_level;
  jcl_pkg::ev_t                 ev;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      stick_threshold <= jcl_pkg::THRESH_RESET;
    end else if (cfg_wr_en) begin
      stick_threshold <= cfg_wr_data;
    end
  end

  assign hi_level = jcl_pkg::REST_TOP - {1'b0, stick_threshold};

  // classification, later tests win
  always_comb begin
    ev = jcl_pkg::EV_NONE;
    if (!button_n) ev = jcl_pkg::EV_PRESS;
    if (x_sample <= {1'b0, stick_threshold}) ev = jcl_pkg::EV_DOWN;
    if (x_sample >= hi_level) ev = jcl_pkg::EV_UP;
    if (y_sample <= {1'b0, stick_threshold}) ev = jcl_pkg::EV_LEFT;
    if (y_sample >= hi_level) ev = jcl_pkg::EV_RIGHT;
  end

  // accept while the queue has room
  assign in_stall   = queue_full;
  assign push.valid = in_valid && !queue_full;
  assign push.ev    = ev;

endmodule

/* rtl/jcl_queue.sv */
module jcl_queue (
  input  logic           clk,
  input  logic           rst,
  input  jcl_pkg::push_t push,
  input  logic           pop,
  output logic           full,
  output logic           not_empty,
  output jcl_pkg::ev_t   head
);

  jcl_pkg::ev_t slots [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   fill;
  logic         do_push;
  logic         do_pop;

  assign full      = (fill == 2'd2);
  assign not_empty = (fill != 2'd0);
  assign head      = slots[rd_ptr];
  assign do_push   = push.valid && !full;
  assign do_pop    = pop && not_empty;

  // two-entry event queue
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push.ev;
  end

endmodule

/* rtl/jcl_back.sv */
module jcl_back #(
  parameter int CODE_LENGTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         ev_valid,
  input  jcl_pkg::ev_t ev_in,
  output logic         ev_pop,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [1:0]   lock_mode,
  output logic [2:0]   stick_event,
  output logic [1:0]   motor_command,
  output logic [1:0]   led_command,
  output logic [1:0]   entered_count,
  output logic         code_checked,
  output logic         code_matched
);

  localparam int CW = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam logic [CW-1:0] LAST = CW'(CODE_LENGTH - 1);

  jcl_pkg::mode_t  mode, mode_next;
  jcl_pkg::ev_t    pending, pending_next;
  logic [CW-1:0]   count, count_next;
  jcl_pkg::ev_t    entry_symbols [CODE_LENGTH];
  jcl_pkg::ev_t    stored_code [CODE_LENGTH];
  jcl_pkg::ev_t    entry_new [CODE_LENGTH];
  logic            active;
  logic            commit;
  logic            full_entry;
  logic            match;
  logic            is_press;
  logic            wr_entry;
  logic            wr_code;
  jcl_pkg::motor_t motor;
  jcl_pkg::led_t   led;
  logic            checked;
  logic [CW+1:0]   count_ext;

  // take an event when the output register is free or draining
  assign ev_pop = ev_valid && (!out_valid || !out_stall);

  // symbol cache and entry count
  always_comb begin
    active     = (mode != jcl_pkg::MODE_INIT);
    is_press   = (ev_in == jcl_pkg::EV_PRESS);
    commit     = active && (ev_in < jcl_pkg::EV_UP) && (pending != jcl_pkg::EV_NONE);
    full_entry = commit && (count == LAST);
    if (active && ev_in >= jcl_pkg::EV_UP) begin
      pending_next = ev_in;
    end else if (commit) begin
      pending_next = jcl_pkg::EV_NONE;
    end else begin
      pending_next = pending;
    end
    if (full_entry) begin
      count_next = '0;
    end else if (commit) begin
      count_next = count + CW'(1);
    end else begin
      count_next = count;
    end
    wr_code  = commit && (mode == jcl_pkg::MODE_CHANGE);
    wr_entry = commit && (mode != jcl_pkg::MODE_CHANGE);
  end

  // compare the entry including the symbol written this tick
  always_comb begin
    match = 1'b1;
    for (int k = 0; k < CODE_LENGTH; k++) begin
      entry_new[k] = (wr_entry && count == CW'(k)) ? pending : entry_symbols[k];
      if (entry_new[k] != stored_code[k]) match = 1'b0;
    end
  end

  // next mode
  always_comb begin
    mode_next = mode;
    case (mode)
      jcl_pkg::MODE_INIT: begin
        mode_next = jcl_pkg::MODE_LOCKED;
      end
      jcl_pkg::MODE_LOCKED: begin
        if (full_entry && match) mode_next = jcl_pkg::MODE_UNLOCKED;
      end
      jcl_pkg::MODE_UNLOCKED: begin
        if (is_press) mode_next = jcl_pkg::MODE_CHANGE;
        if (full_entry && match) mode_next = jcl_pkg::MODE_LOCKED;
      end
      jcl_pkg::MODE_CHANGE: begin
        if (full_entry) mode_next = jcl_pkg::MODE_UNLOCKED;
      end
      default: mode_next = jcl_pkg::MODE_INIT;
    endcase
  end

  // command pulses
  always_comb begin
    motor   = jcl_pkg::MOTOR_NONE;
    led     = jcl_pkg::LED_NONE;
    checked = 1'b0;
    case (mode)
      jcl_pkg::MODE_LOCKED: begin
        checked = full_entry;
        if (full_entry) begin
          if (match) begin
            led   = jcl_pkg::LED_ALL_ON;
            motor = jcl_pkg::MOTOR_OPEN;
          end else begin
            led = jcl_pkg::LED_WRONG;
          end
        end
      end
      jcl_pkg::MODE_UNLOCKED: begin
        checked = full_entry;
        if (is_press) led = jcl_pkg::LED_DEFAULT;
        if (full_entry && match) motor = jcl_pkg::MOTOR_CLOSE;
      end
      jcl_pkg::MODE_CHANGE: begin
        if (full_entry) led = jcl_pkg::LED_ALL_ON;
      end
      default: begin
        motor = jcl_pkg::MOTOR_NONE;
      end
    endcase
  end

  assign count_ext = {2'b00, count_next};

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= jcl_pkg::MODE_INIT;
      pending   <= jcl_pkg::EV_NONE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ev_pop) begin
        mode    <= mode_next;
        pending <= pending_next;
        count   <= count_next;
      end
      if (ev_pop) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // stored code, factory value at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CODE_LENGTH; k++) begin
        stored_code[k] <= jcl_pkg::default_symbol(k);
      end
    end else if (ev_pop && wr_code) begin
      stored_code[count] <= pending;
    end
  end

  // entry symbols
  always_ff @(posedge clk) begin
    if (ev_pop && wr_entry) entry_symbols[count] <= pending;
  end

  // result register
  always_ff @(posedge clk) begin
    if (ev_pop) begin
      lock_mode     <= mode_next;
      stick_event   <= ev_in;
      motor_command <= motor;
      led_command   <= led;
      entered_count <= count_ext[1:0];
      code_checked  <= checked;
      code_matched  <= checked && match;
    end
  end

endmodule
